// ----- hw/rtl/mlbe_pkg.sv -----
// Shared types, constants and helpers for the multi-LED blink engine.
// No dependencies; every other file refers to it by scoped names.
package mlbe_pkg;

    // Channel count and counter width of the blink engine
    localparam int CHANNELS    = 6;
    localparam int COUNT_WIDTH = 16;

    // Fixed field widths of the transaction ports
    localparam int MODE_W = 2;
    localparam int MASK_W = 6;
    localparam int HALF_W = 16;
    localparam int CYC_W  = 15;
    localparam int OUT_W  = 6;

    // Wide enough for any field value and any counter ceiling
    localparam int WIDE_W = 33;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    // Command queue depth and pointer width
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = 1;
    localparam int FIFO_CNT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_START = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_LEVEL = 2'd3
    } t_mode;

    // Classified command as it travels from front to back
    typedef struct packed {
        t_mode                  mode;
        logic [CHANNELS-1:0]    sel;
        logic [COUNT_WIDTH-1:0] half;
        logic [COUNT_WIDTH-1:0] trans;
        logic                   level;
        logic                   set_normal;
    } t_cmd;

    // Queue status seen by the front, the back and the checks
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    // Clamp a value to the largest count
    function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [WIDE_W-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        if (v > WIDE_W'(COUNT_MAX)) begin
            r = COUNT_MAX;
        end else begin
            r = v[COUNT_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mlbe_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
// Depends on mlbe_pkg.
module mlbe_front (
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mlbe_pkg::MODE_W-1:0] i_mode,
    input  logic [mlbe_pkg::MASK_W-1:0] i_led_mask,
    input  logic [mlbe_pkg::HALF_W-1:0] i_half_period,
    input  logic [mlbe_pkg::CYC_W-1:0]  i_cycles,
    input  logic                        i_level,
    input  logic                        i_set_normal,
    input  mlbe_pkg::t_fifo_stat        i_stat,
    output logic                        o_push,
    output mlbe_pkg::t_cmd              o_cmd
);

    logic [mlbe_pkg::CHANNELS-1:0] sel;

    // Take a transaction whenever the queue has room
    assign o_ready = !i_stat.full;
    assign o_push  = i_valid && !i_stat.full;

    // Drop mask bits beyond the port, zero channels beyond it
    always_comb begin
        for (int i = 0; i < mlbe_pkg::CHANNELS; i++) begin
            if (i < mlbe_pkg::MASK_W) begin
                sel[i] = i_led_mask[i];
            end else begin
                sel[i] = 1'b0;
            end
        end
    end

    // Precompute saturated targets so the back only compares
    always_comb begin
        o_cmd.mode       = mlbe_pkg::t_mode'(i_mode);
        o_cmd.sel        = sel;
        o_cmd.half       = mlbe_pkg::sat_count(mlbe_pkg::WIDE_W'(i_half_period));
        o_cmd.trans      = mlbe_pkg::sat_count(mlbe_pkg::WIDE_W'(i_cycles) << 1);
        o_cmd.level      = i_level;
        o_cmd.set_normal = i_set_normal;
    end

endmodule

// ----- hw/rtl/mlbe_cmd_fifo.sv -----
// Short command queue between front and back.
// Depends on mlbe_pkg.
module mlbe_cmd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mlbe_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output mlbe_pkg::t_cmd       o_cmd,
    output mlbe_pkg::t_fifo_stat o_stat
);

    mlbe_pkg::t_cmd                  r_mem [mlbe_pkg::FIFO_DEPTH];
    logic [mlbe_pkg::FIFO_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [mlbe_pkg::FIFO_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [mlbe_pkg::FIFO_CNT_W-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == mlbe_pkg::FIFO_CNT_W'(mlbe_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_cmd        = r_mem[r_rd_ptr];

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hw/rtl/mlbe_back.sv -----
// Back end: per-channel blink state, command execution and the result register.
// Depends on mlbe_pkg.
module mlbe_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mlbe_pkg::t_cmd             i_cmd,
    input  mlbe_pkg::t_fifo_stat       i_stat,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mlbe_pkg::OUT_W-1:0] o_pin_levels,
    output logic [mlbe_pkg::OUT_W-1:0] o_active_mask
);

    localparam int CH = mlbe_pkg::CHANNELS;
    localparam int CW = mlbe_pkg::COUNT_WIDTH;

    logic [CH-1:0] r_running, n_running;
    logic [CW-1:0] r_tick    [CH];
    logic [CW-1:0] n_tick    [CH];
    logic [CW-1:0] r_half    [CH];
    logic [CW-1:0] n_half    [CH];
    logic [CW-1:0] r_target  [CH];
    logic [CW-1:0] n_target  [CH];
    logic [CW-1:0] r_trans   [CH];
    logic [CW-1:0] n_trans   [CH];
    logic [CH-1:0] r_phase, n_phase;
    logic [CH-1:0] r_idle, n_idle;
    logic [CH-1:0] r_pin, n_pin;

    logic                       r_valid;
    logic [mlbe_pkg::OUT_W-1:0] r_pins, n_pins;
    logic [mlbe_pkg::OUT_W-1:0] r_act, n_act;

    // Pop when the result register is free or being emptied
    assign o_pop         = !i_stat.empty && (!r_valid || i_ready);
    assign o_valid       = r_valid;
    assign o_pin_levels  = r_pins;
    assign o_active_mask = r_act;

    // Execute one command across all channels in parallel
    always_comb begin
        logic [CW-1:0] tc;
        n_running = r_running;
        n_phase   = r_phase;
        n_idle    = r_idle;
        n_pin     = r_pin;
        tc        = '0;
        for (int i = 0; i < CH; i++) begin
            n_tick[i]   = r_tick[i];
            n_half[i]   = r_half[i];
            n_target[i] = r_target[i];
            n_trans[i]  = r_trans[i];
            case (i_cmd.mode)
                mlbe_pkg::MODE_TICK: begin
                    if (r_running[i]) begin
                        tc = r_tick[i] + 1'b1;
                        n_tick[i] = tc;
                        if (tc >= r_half[i]) begin
                            n_tick[i]  = '0;
                            n_pin[i]   = r_phase[i];
                            n_phase[i] = !r_phase[i];
                            if (r_target[i] != '0) begin
                                n_trans[i] = r_trans[i] + 1'b1;
                            end
                        end
                        // Stop once the requested transitions are done
                        if (r_target[i] != '0 && n_trans[i] >= r_target[i]) begin
                            n_running[i] = 1'b0;
                            n_tick[i]    = '0;
                            n_trans[i]   = '0;
                            n_pin[i]     = r_idle[i];
                        end
                    end
                end
                mlbe_pkg::MODE_START: begin
                    if (i_cmd.sel[i]) begin
                        n_tick[i]    = '0;
                        n_running[i] = 1'b1;
                        n_half[i]    = i_cmd.half;
                        n_phase[i]   = 1'b1;
                        n_target[i]  = i_cmd.trans;
                        n_trans[i]   = '0;
                    end
                end
                mlbe_pkg::MODE_STOP: begin
                    if (i_cmd.sel[i]) begin
                        n_running[i] = 1'b0;
                        n_tick[i]    = '0;
                        n_pin[i]     = r_idle[i];
                    end
                end
                mlbe_pkg::MODE_LEVEL: begin
                    if (i_cmd.sel[i]) begin
                        if (i_cmd.set_normal) begin
                            n_idle[i] = i_cmd.level;
                        end
                        n_pin[i] = i_cmd.level;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Gather the visible channels into the result
    always_comb begin
        for (int i = 0; i < mlbe_pkg::OUT_W; i++) begin
            if (i < CH) begin
                n_pins[i] = n_pin[i];
                n_act[i]  = n_running[i];
            end else begin
                n_pins[i] = 1'b0;
                n_act[i]  = 1'b0;
            end
        end
    end

    // Channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
            r_phase   <= '1;
            r_idle    <= '0;
            r_pin     <= '0;
            for (int i = 0; i < CH; i++) begin
                r_tick[i]   <= '0;
                r_half[i]   <= '0;
                r_target[i] <= '0;
                r_trans[i]  <= '0;
            end
        end else if (o_pop) begin
            r_running <= n_running;
            r_phase   <= n_phase;
            r_idle    <= n_idle;
            r_pin     <= n_pin;
            for (int i = 0; i < CH; i++) begin
                r_tick[i]   <= n_tick[i];
                r_half[i]   <= n_half[i];
                r_target[i] <= n_target[i];
                r_trans[i]  <= n_trans[i];
            end
        end
    end

    // Result register: load on pop, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pins <= n_pins;
            r_act  <= n_act;
        end
    end

endmodule

// ----- hw/rtl/multi_led_blink_engine_core.sv -----
// Top level of the multi-LED blink engine: front, command queue and back.
// Depends on mlbe_pkg, mlbe_front, mlbe_cmd_fifo and mlbe_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  event in | i_valid / o_ready  | i_mode i_led_mask i_half_period i_cycles
//           |                    | i_level i_set_normal
//  result   | o_valid / i_ready  | o_pin_levels o_active_mask
//
// One event per cycle sustained while results are taken; a taken event waits in
// the queue until its pop at the queue head loads the result register.
// The back updates all channels together for each command that it pops.
// Synchronous active-low reset resets all channel state and empties the queue.
// A stalled result holds in its register while the queue takes up to two more.
module multi_led_blink_engine_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [mlbe_pkg::MODE_W-1:0]          i_mode,
    input  logic [mlbe_pkg::MASK_W-1:0]          i_led_mask,
    input  logic [mlbe_pkg::HALF_W-1:0]          i_half_period,
    input  logic [mlbe_pkg::CYC_W-1:0]           i_cycles,
    input  logic                                 i_level,
    input  logic                                 i_set_normal,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [mlbe_pkg::OUT_W-1:0]           o_pin_levels,
    output logic [mlbe_pkg::OUT_W-1:0]           o_active_mask
);

    mlbe_pkg::t_cmd       push_cmd;
    mlbe_pkg::t_cmd       head_cmd;
    mlbe_pkg::t_fifo_stat fifo_stat;
    logic                 push;
    logic                 pop;

    mlbe_front u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_led_mask    (i_led_mask),
        .i_half_period (i_half_period),
        .i_cycles      (i_cycles),
        .i_level       (i_level),
        .i_set_normal  (i_set_normal),
        .i_stat        (fifo_stat),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    mlbe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (fifo_stat)
    );

    mlbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_stat        (fifo_stat),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pin_levels  (o_pin_levels),
        .o_active_mask (o_active_mask)
    );

    // Queue cannot be full and empty at once
    a_fifo_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(fifo_stat.full && fifo_stat.empty))
        else $error("command queue reports full and empty");

    // Back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !fifo_stat.empty)
        else $error("pop from empty command queue");

    // A new result only follows a pop
    a_valid_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> $past(pop))
        else $error("result raised without a command");

    // Front takes no transaction while the queue is full
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.full |-> !push)
        else $error("push into full command queue");

endmodule
